// ----- rtl/rbpa_pkg.sv -----
// ============================================================================
// rbpa_pkg - shared types and codes of the random block pool allocator
// Field widths, word layouts, operation and status codes, register indexes.
// ============================================================================
package rbpa_pkg;

    localparam int BLK_W  = 10;
    localparam int POS_W  = 10;
    localparam int DEV_W  = 3;
    localparam int NUM_W  = 32;
    localparam int RND_W  = 32;
    localparam int FREE_W = 11;
    localparam int STAT_W = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DCNT_W     = 4;
    localparam int BCNT_W     = 11;

    // Operation codes; the fourth code does nothing and answers ok.
    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_CLAIMED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_ILL_NUM   = 3'd2;
    localparam logic [STAT_W-1:0] ST_POOL_EMPT = 3'd3;
    localparam logic [STAT_W-1:0] ST_DEV_EMPT  = 3'd4;
    localparam logic [STAT_W-1:0] ST_ILL_DEV   = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd1;

    localparam logic [DCNT_W-1:0] DEVICE_COUNT_RST = 4'd1;
    localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST  = 11'd1024;

    typedef struct packed {
        logic [1:0]       op;
        logic [DEV_W-1:0] device;
        logic [BLK_W-1:0] block;
        logic             header_valid;
        logic             header_last;
        logic [NUM_W-1:0] header_number;
        logic [RND_W-1:0] random_word;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  chosen_block;
        logic [POS_W-1:0]  list_position;
        logic              prev_rewrite;
        logic [BLK_W-1:0]  prev_block;
        logic [FREE_W-1:0] free_left;
    } t_out_word;

    typedef struct packed {
        logic [DCNT_W-1:0] device_count;
        logic [BCNT_W-1:0] block_count;
    } t_cfg;

    // One entry of an owner list.
    typedef struct packed {
        logic             valid;
        logic [BLK_W-1:0] block;
    } t_entry;

endpackage

// ----- rtl/rbpa_ram.sv -----
// ============================================================================
// rbpa_ram - two read ports, one write port synchronous memory
// Read data is registered and holds while no read is issued.
// ============================================================================
module rbpa_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 10
) (
    input  logic              i_clk,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata
);

    logic [DATA_W-1:0] r_mem [1 << ADDR_W];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/rbpa_core.sv -----
// ============================================================================
// rbpa_core - sequencer and read-modify-write datapath of the allocator
// Owns the owner list memory, the free pool memory, the per-device counts,
// the pool count, the clearing pass and the result register.
// ============================================================================
module rbpa_core import rbpa_pkg::*; #(
    parameter int MAX_BLOCKS  = 1024,
    parameter int MAX_DEVICES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    localparam int AW        = $clog2(MAX_BLOCKS);
    localparam int NBW       = $clog2(MAX_BLOCKS + 1);
    localparam int CW        = $clog2(2 * MAX_BLOCKS + 1);
    localparam int DIW       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int NDW       = $clog2(MAX_DEVICES + 1);
    localparam int OAW       = DIW + AW;
    localparam int CNT_DEPTH = 1 << DIW;
    localparam int ENT_W     = $bits(t_entry);
    localparam int PROD_W    = NBW + RND_W;

    typedef enum logic [1:0] {
        S_CLR,
        S_IDLE,
        S_WB
    } t_state;

    // Fold a list position into the memory row; positions stay below twice
    // the block limit, so one subtract does.
    function automatic logic [AW-1:0] wrap_pos(input logic [CW-1:0] x);
        logic [CW-1:0] y;
        y = (x >= CW'(MAX_BLOCKS)) ? x - CW'(MAX_BLOCKS) : x;
        return AW'(y);
    endfunction

    t_state           r_state;
    logic [OAW-1:0]   r_clr_addr;
    logic [CW-1:0]    r_count [CNT_DEPTH];
    logic [NBW-1:0]   r_fc;
    logic             r_out_valid;
    t_out_word        r_out;
    t_in_word         r_item;
    logic [AW-1:0]    r_pidx;
    logic [AW-1:0]    r_pos_fr;

    logic [NBW-1:0]   nb;
    logic [NDW-1:0]   nd;

    logic             in_acc;
    logic [DIW-1:0]   in_dix;
    logic [CW-1:0]    in_cnt;
    logic [CW-1:0]    in_cm1;
    logic [CW-1:0]    in_cm2;
    logic [PROD_W-1:0] prod;
    logic [AW-1:0]    in_pidx;

    logic [DIW-1:0]   wb_dix;
    logic [CW-1:0]    cnt;
    logic [CW-1:0]    cm1;
    logic             devbad;
    logic             push_ok;
    logic             commit;

    logic [OAW-1:0]   own_raddr_a;
    logic [OAW-1:0]   own_raddr_b;
    logic [ENT_W-1:0] own_rdata_a;
    logic [ENT_W-1:0] own_rdata_b;
    t_entry           own_a;
    t_entry           own_b;
    logic             own_we_op;
    logic [OAW-1:0]   own_waddr_op;
    t_entry           own_wdata_op;
    logic             own_we;
    logic [OAW-1:0]   own_waddr;
    t_entry           own_wdata;

    logic [AW-1:0]    pool_raddr_b;
    logic [BLK_W-1:0] pool_rdata_a;
    logic [BLK_W-1:0] pool_rdata_b;
    logic             pool_we_op;
    logic [AW-1:0]    pool_waddr;
    logic [BLK_W-1:0] pool_wdata;

    t_out_word        n_out;
    logic [CW-1:0]    n_count;
    logic [NBW-1:0]   n_fc;

    // Effective limits.
    assign nb = (32'(i_cfg.block_count) > 32'(MAX_BLOCKS)) ? NBW'(MAX_BLOCKS)
                                                           : NBW'(i_cfg.block_count);
    assign nd = (32'(i_cfg.device_count) > 32'(MAX_DEVICES)) ? NDW'(MAX_DEVICES)
                                                             : NDW'(i_cfg.device_count);

    // Accept cycle: issue the reads.
    assign in_acc  = i_in_valid && (r_state == S_IDLE);
    assign in_dix  = DIW'(i_in_data.device);
    assign in_cnt  = r_count[in_dix];
    assign in_cm1  = in_cnt - CW'(1);
    assign in_cm2  = in_cnt - CW'(2);
    assign prod    = PROD_W'(r_fc) * PROD_W'(i_in_data.random_word);
    assign in_pidx = AW'(prod[PROD_W-1:RND_W]);

    assign own_raddr_a = (i_in_data.op == OP_SCAN)
                       ? {in_dix, AW'(i_in_data.header_number)}
                       : {in_dix, wrap_pos(in_cm1)};
    assign own_raddr_b = (i_in_data.op == OP_ALLOC)
                       ? {in_dix, wrap_pos(in_cm1)}
                       : {in_dix, wrap_pos(in_cm2)};
    assign pool_raddr_b = AW'(r_fc - NBW'(1));

    rbpa_ram #(
        .ADDR_W (OAW),
        .DATA_W (ENT_W)
    ) u_own_ram (
        .i_clk     (i_clk),
        .i_re      (in_acc),
        .i_raddr_a (own_raddr_a),
        .i_raddr_b (own_raddr_b),
        .o_rdata_a (own_rdata_a),
        .o_rdata_b (own_rdata_b),
        .i_we      (own_we),
        .i_waddr   (own_waddr),
        .i_wdata   (ENT_W'(own_wdata))
    );

    rbpa_ram #(
        .ADDR_W (AW),
        .DATA_W (BLK_W)
    ) u_pool_ram (
        .i_clk     (i_clk),
        .i_re      (in_acc),
        .i_raddr_a (in_pidx),
        .i_raddr_b (pool_raddr_b),
        .o_rdata_a (pool_rdata_a),
        .o_rdata_b (pool_rdata_b),
        .i_we      (commit && pool_we_op),
        .i_waddr   (pool_waddr),
        .i_wdata   (pool_wdata)
    );

    assign own_a = t_entry'(own_rdata_a);
    assign own_b = t_entry'(own_rdata_b);

    // Write-back cycle: decide and modify.
    assign wb_dix  = DIW'(r_item.device);
    assign cnt     = r_count[wb_dix];
    assign cm1     = cnt - CW'(1);
    assign devbad  = 32'(r_item.device) >= 32'(nd);
    assign push_ok = r_fc < nb;
    assign commit  = (r_state == S_WB) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out        = '0;
        n_out.status = ST_OK;
        own_we_op    = 1'b0;
        own_waddr_op = '0;
        own_wdata_op = '0;
        pool_we_op   = 1'b0;
        pool_waddr   = '0;
        pool_wdata   = '0;
        n_count      = cnt;
        n_fc         = r_fc;
        unique case (r_item.op)
            OP_SCAN: begin
                priority if (32'(r_item.block) >= 32'(nb)) begin
                    n_out.status = ST_ILL_NUM;
                end else if (!r_item.header_valid) begin
                    n_out.chosen_block = r_item.block;
                    if (push_ok) begin
                        pool_we_op = 1'b1;
                        pool_waddr = AW'(r_fc);
                        pool_wdata = r_item.block;
                        n_fc       = r_fc + NBW'(1);
                    end
                end else if (devbad) begin
                    n_out.status = ST_ILL_DEV;
                end else if (r_item.header_number >= 32'(nb)) begin
                    n_out.status = ST_ILL_NUM;
                end else if (own_a.valid) begin
                    n_out.status = ST_CLAIMED;
                end else begin
                    own_we_op           = 1'b1;
                    own_waddr_op        = {wb_dix, AW'(r_item.header_number)};
                    own_wdata_op.valid  = 1'b1;
                    own_wdata_op.block  = r_item.block;
                    n_count             = cnt + CW'(1);
                    n_out.chosen_block  = r_item.block;
                    n_out.list_position = POS_W'(r_item.header_number);
                end
            end
            OP_ALLOC: begin
                priority if (devbad) begin
                    n_out.status = ST_ILL_DEV;
                end else if (r_fc == '0) begin
                    n_out.status = ST_POOL_EMPT;
                end else if (32'(cnt) >= 32'(nb)) begin
                    n_out.status = ST_ILL_NUM;
                end else begin
                    // swap the pool tail into the hole
                    pool_we_op          = 1'b1;
                    pool_waddr          = r_pidx;
                    pool_wdata          = pool_rdata_b;
                    n_fc                = r_fc - NBW'(1);
                    own_we_op           = 1'b1;
                    own_waddr_op        = {wb_dix, AW'(cnt)};
                    own_wdata_op.valid  = 1'b1;
                    own_wdata_op.block  = pool_rdata_a;
                    n_count             = cnt + CW'(1);
                    n_out.chosen_block  = pool_rdata_a;
                    n_out.list_position = POS_W'(cnt);
                    if ((cnt != '0) && own_b.valid) begin
                        n_out.prev_rewrite = 1'b1;
                        n_out.prev_block   = own_b.block;
                    end
                end
            end
            OP_FREE: begin
                priority if (devbad) begin
                    n_out.status = ST_ILL_DEV;
                end else if (cnt == '0) begin
                    n_out.status = ST_DEV_EMPT;
                end else begin
                    own_we_op           = 1'b1;
                    own_waddr_op        = {wb_dix, r_pos_fr};
                    n_count             = cm1;
                    n_out.list_position = POS_W'(cm1);
                    if (own_a.valid) begin
                        n_out.chosen_block = own_a.block;
                        if (push_ok) begin
                            pool_we_op = 1'b1;
                            pool_waddr = AW'(r_fc);
                            pool_wdata = own_a.block;
                            n_fc       = r_fc + NBW'(1);
                        end
                    end
                    if ((cm1 != '0) && own_b.valid) begin
                        n_out.prev_rewrite = 1'b1;
                        n_out.prev_block   = own_b.block;
                    end
                end
            end
            default: begin
            end
        endcase
        n_out.free_left = FREE_W'(n_fc);
    end

    assign own_we    = (r_state == S_CLR) || (commit && own_we_op);
    assign own_waddr = (r_state == S_CLR) ? r_clr_addr : own_waddr_op;
    assign own_wdata = (r_state == S_CLR) ? t_entry'('0) : own_wdata_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_fc        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CNT_DEPTH; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + OAW'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLR;
                end
            endcase
            if (commit) begin
                r_count[wb_dix] <= n_count;
                r_fc            <= n_fc;
                r_out           <= n_out;
                r_out_valid     <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item   <= i_in_data;
            r_pidx   <= in_pidx;
            r_pos_fr <= wrap_pos(in_cm1);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/random_block_pool_allocator.sv -----
// ============================================================================
// random_block_pool_allocator - free block pool with per-device block lists
// Top level: configuration registers and the allocator core.
// ============================================================================
// Each operation reads the owner list memory and the free pool memory in the
// accept cycle (two ports each, the random pool index formed by one multiply
// of the pool count by the random word); in the write-back state the result
// is decided, the memories are written as the operation needs and the result
// word is loaded into the output register. A result held by a stalled output
// keeps the next word in write-back until the stall lifts, and no new word is
// taken before the last one is written back. After reset the owner list
// memory is swept clear, one entry a cycle, through its
// 2^ceil(log2(MAX_DEVICES)) * 2^ceil(log2(MAX_BLOCKS)) entries (8192 with the
// default parameters); the input stalls during the sweep, while configuration
// writes are taken at any time (ready is always high). Configure only while
// idle. The end-of-list mark in a scanned header does not affect any result.
// ============================================================================
module random_block_pool_allocator import rbpa_pkg::*; #(
    parameter int MAX_BLOCKS  = 1024,
    parameter int MAX_DEVICES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // operation words in
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_data,
    // result words out
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_data
);

    t_cfg r_cfg;

    // Take every configuration write at once; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_count <= DEVICE_COUNT_RST;
            r_cfg.block_count  <= BLOCK_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEVICE_COUNT: r_cfg.device_count <= i_cfg_data[DCNT_W-1:0];
                CFG_BLOCK_COUNT:  r_cfg.block_count  <= i_cfg_data[BCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Core: clearing sweep, read/modify/write of both memories, result
    // register that lets the next word in while a result waits.
    rbpa_core #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .MAX_DEVICES (MAX_DEVICES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/rbpa_checker.sv -----
// ============================================================================
// rbpa_checker - port-level assertions for the allocator
// Bound to the top level; watches the channels over time.
// ============================================================================
module rbpa_checker import rbpa_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_word             o_out_data
);

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // One word in flight: stall the cycle after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on back-to-back cycles");

    // Failed operations report no block.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |->
            (o_out_data.chosen_block == '0) && (o_out_data.list_position == '0)
            && !o_out_data.prev_rewrite && (o_out_data.prev_block == '0))
        else $error("failed operation carries block fields");

    // No rewrite means no rewrite target.
    a_prev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.prev_rewrite |-> (o_out_data.prev_block == '0))
        else $error("prev_block set without prev_rewrite");

endmodule

bind random_block_pool_allocator rbpa_checker u_rbpa_checker (.*);

// ----- verif/tb.sv -----
// ============================================================================
// tb - self-checking bench for random_block_pool_allocator
// Drives operation words (scan, allocate, free, the unused code) through the
// valid/stall input, sets the device and block counts between phases through
// the register channel, and checks every result word field by field against
// a bench-side copy of the free pool and the owner lists. A short table of
// directed words comes first; seeded random phases follow under several
// register settings, with random idling on both sides.
// ============================================================================
module tb;
    import rbpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BLOCKS  = 1024;
    localparam int MAX_DEVICES = 8;

    // The fourth operation code: changes nothing, answers ok.
    localparam logic [1:0] OP_IDLE = 2'd3;

    // Cycles the receiver holds off in one long stretch.
    localparam int LONG_HOLD = 400;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT connections
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_word             o_out_data;

    random_block_pool_allocator #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .MAX_DEVICES (MAX_DEVICES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit: well beyond the slowest legal run, including the list sweep.
    initial begin
        #5ms;
        $display("** random_block_pool_allocator: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Bench copy of the allocator state
    // ------------------------------------------------------------------------
    t_entry            owner_list [MAX_DEVICES][MAX_BLOCKS];
    int unsigned       owner_count[MAX_DEVICES];
    t_entry            owner_tail [MAX_DEVICES];
    logic [BLK_W-1:0]  free_pool  [MAX_BLOCKS];
    int unsigned       pool_fill;
    logic [DCNT_W-1:0] devices_reg = DEVICE_COUNT_RST;
    logic [BCNT_W-1:0] blocks_reg  = BLOCK_COUNT_RST;

    // Result words still owed by the DUT, oldest first.
    t_out_word due_results[$];

    int mismatches;
    int results_seen;
    int op_tally[4];
    int status_tally[8];
    int settings_used;

    // Shared idling controls.
    bit no_idle;
    bit hold_go;
    bit rx_hold;

    function automatic int unsigned devices_eff();
        return (devices_reg > MAX_DEVICES) ? MAX_DEVICES : devices_reg;
    endfunction

    function automatic int unsigned blocks_eff();
        return (blocks_reg > MAX_BLOCKS) ? MAX_BLOCKS : blocks_reg;
    endfunction

    // Drop the block silently once the pool already holds block_count entries.
    function automatic void pool_push(input logic [BLK_W-1:0] blk);
        if (pool_fill < blocks_eff() && pool_fill < MAX_BLOCKS) begin
            free_pool[pool_fill] = blk;
            pool_fill++;
        end
    endfunction

    // Apply one operation word to the bench state and return the word owed.
    function automatic t_out_word step_pool(input t_in_word w);
        t_out_word        r;
        int unsigned      nb;
        int unsigned      cnt;
        bit               dev_bad;
        logic [63:0]      prod;
        logic [BLK_W-1:0] idx;
        t_entry           e;
        r       = '0;
        nb      = blocks_eff();
        dev_bad = (w.device >= devices_eff());
        case (w.op)
            OP_SCAN: begin
                // Block range first, then device, then number, then claimed.
                if (w.block >= nb) begin
                    r.status = ST_ILL_NUM;
                end else if (!w.header_valid) begin
                    pool_push(w.block);
                    r.chosen_block = w.block;
                end else if (dev_bad) begin
                    r.status = ST_ILL_DEV;
                end else if (w.header_number >= nb) begin
                    r.status = ST_ILL_NUM;
                end else if (owner_list[w.device][w.header_number[9:0]].valid) begin
                    r.status = ST_CLAIMED;
                end else begin
                    owner_list[w.device][w.header_number[9:0]] = '{1'b1, w.block};
                    owner_count[w.device]++;
                    if (w.header_last)
                        owner_tail[w.device] = '{1'b1, w.block};
                    r.chosen_block  = w.block;
                    r.list_position = w.header_number[9:0];
                end
            end
            OP_ALLOC: begin
                if (dev_bad) begin
                    r.status = ST_ILL_DEV;
                end else if (pool_fill == 0) begin
                    r.status = ST_POOL_EMPT;
                end else if (owner_count[w.device] >= nb) begin
                    r.status = ST_ILL_NUM;
                end else begin
                    // Index is the high word of count * random, which stays below the pool count.
                    prod = 64'(pool_fill) * 64'(w.random_word);
                    idx  = prod[41:32];
                    r.chosen_block = free_pool[idx];
                    free_pool[idx] = free_pool[10'(pool_fill - 1)];
                    pool_fill--;
                    cnt = owner_count[w.device];
                    owner_list[w.device][cnt[9:0]] = '{1'b1, r.chosen_block};
                    owner_count[w.device] = cnt + 1;
                    owner_tail[w.device]  = '{1'b1, r.chosen_block};
                    r.list_position = cnt[9:0];
                    if (cnt > 0) begin
                        e = owner_list[w.device][10'(cnt - 1)];
                        if (e.valid) begin
                            r.prev_rewrite = 1'b1;
                            r.prev_block   = e.block;
                        end
                    end
                end
            end
            OP_FREE: begin
                if (dev_bad) begin
                    r.status = ST_ILL_DEV;
                end else if (owner_count[w.device] == 0) begin
                    r.status = ST_DEV_EMPT;
                end else begin
                    cnt = owner_count[w.device] - 1;
                    e   = owner_list[w.device][cnt[9:0]];
                    // A gap frees nothing but the count still shrinks.
                    if (e.valid) begin
                        r.chosen_block = e.block;
                        pool_push(e.block);
                    end
                    owner_list[w.device][cnt[9:0]] = '0;
                    owner_count[w.device] = cnt;
                    r.list_position = cnt[9:0];
                    if (cnt == 0) begin
                        owner_tail[w.device] = '0;
                    end else begin
                        e = owner_list[w.device][10'(cnt - 1)];
                        owner_tail[w.device] = e;
                        if (e.valid) begin
                            r.prev_rewrite = 1'b1;
                            r.prev_block   = e.block;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.free_left = pool_fill[FREE_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t: result %0d: %s got %0d, want %0d", $realtime, results_seen,
                 what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (due_results.size() == 0) begin
            flag_mismatch("unexpected word, status", got.status, 0);
            return;
        end
        want = due_results.pop_front();
        if (got.status !== want.status)
            flag_mismatch("status", got.status, want.status);
        if (got.chosen_block !== want.chosen_block)
            flag_mismatch("chosen_block", got.chosen_block, want.chosen_block);
        if (got.list_position !== want.list_position)
            flag_mismatch("list_position", got.list_position, want.list_position);
        if (got.prev_rewrite !== want.prev_rewrite)
            flag_mismatch("prev_rewrite", got.prev_rewrite, want.prev_rewrite);
        if (got.prev_block !== want.prev_block)
            flag_mismatch("prev_block", got.prev_block, want.prev_block);
        if (got.free_left !== want.free_left)
            flag_mismatch("free_left", got.free_left, want.free_left);
    endtask

    // Receiver: draw a stall per word, obey the long hold, then take one word.
    initial begin : result_sink
        int        gap;
        t_out_word got;
        wait (rst_n === 1'b1);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0 || rx_hold) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got = o_out_data;
            check_result(got);
            results_seen++;
        end
    end

    // Long hold-off: keep the output stalled while the sender keeps offering.
    initial begin : long_hold
        wait (hold_go);
        rx_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        t_in_word              word;
        bit                    typed;
        t_out_word             want;
    } t_row;

    t_row plan[$];

    function automatic t_in_word word_of(input logic [1:0] op, input int dev, input int blk,
                                         input bit hv, input bit hl,
                                         input logic [31:0] num, input logic [31:0] rnd);
        return t_in_word'{op, 3'(dev), 10'(blk), hv, hl, num, rnd};
    endfunction

    function automatic t_out_word answer(input logic [STAT_W-1:0] st, input int blk,
                                         input int pos, input int fl);
        return t_out_word'{st, 10'(blk), 10'(pos), 1'b0, 10'd0, 11'(fl)};
    endfunction

    function automatic void plan_op(input t_in_word w);
        plan.push_back('{1'b0, '0, '0, w, 1'b0, '0});
    endfunction

    function automatic void plan_chk(input t_in_word w, input t_out_word want);
        plan.push_back('{1'b0, '0, '0, w, 1'b1, want});
    endfunction

    function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
        plan.push_back('{1'b1, idx, 11'(val), '0, 1'b0, '0});
    endfunction

    // Offer one word: idle for a drawn gap, hold it until taken, then log what is owed.
    task automatic issue_op(input t_in_word w, input bit typed, input t_out_word want);
        int        gap;
        t_out_word owed;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        owed = step_pool(w);
        // Directed rows with a typed answer use it; the state still advances.
        if (typed)
            owed = want;
        due_results.push_back(owed);
        op_tally[w.op]++;
        status_tally[owed.status]++;
    endtask

    // Drop valid and hold until every owed word has arrived, then settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx == CFG_DEVICE_COUNT)
            devices_reg = val[DCNT_W-1:0];
        else if (idx == CFG_BLOCK_COUNT)
            blocks_reg = val[BCNT_W-1:0];
        settings_used++;
        @(posedge i_clk);
    endtask

    // Random word, mostly well formed for the current state, some pure noise.
    function automatic t_in_word draw_op();
        t_in_word    w;
        int unsigned nb;
        int unsigned nd;
        int unsigned pick;
        nb = blocks_eff();
        nd = devices_eff();
        w.op            = OP_SCAN;
        w.device        = 3'($urandom);
        w.block         = 10'($urandom);
        w.header_valid  = 1'($urandom);
        w.header_last   = 1'($urandom);
        w.header_number = $urandom;
        w.random_word   = $urandom;
        if (nd > 0 && $urandom_range(0, 9) != 0)
            w.device = 3'($urandom_range(0, nd - 1));
        if (nb > 0 && $urandom_range(0, 9) != 0)
            w.block = 10'($urandom_range(0, nb - 1));
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            w.op = 2'($urandom);
        end else if (pick < 30 || (pick < 45 && pool_fill < 2)) begin
            w.header_valid = 1'b0;
        end else if (pick < 45) begin
            // Claim the next list position mostly, elsewhere now and then.
            w.header_valid  = 1'b1;
            w.header_number = ($urandom_range(0, 3) == 0) ? $urandom_range(0, nb)
                                                          : owner_count[w.device];
        end else if (pick < 75) begin
            w.op = OP_ALLOC;
        end else if (pick < 95) begin
            w.op = OP_FREE;
        end else begin
            w.op = OP_IDLE;
        end
        return w;
    endfunction

    // Register settings for the random phases: extremes and ordinary sizes.
    int unsigned set_devs [8] = '{8, 15, 3, 8, 0, 5, 2, 1};
    int unsigned set_blks [8] = '{1024, 2047, 6, 1, 9, 64, 300, 1024};
    int          set_items[8] = '{200, 120, 80, 60, 30, 140, 60, 60};

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        foreach (owner_list[d, p])
            owner_list[d][p] = '0;
        foreach (owner_count[d]) begin
            owner_count[d] = 0;
            owner_tail[d]  = '0;
        end
        foreach (free_pool[i])
            free_pool[i] = '0;
        pool_fill = 0;

        // Directed table, reset settings first (one device, 1024 blocks).
        plan_chk(word_of(OP_ALLOC, 0, 0, 0, 0, 0, 0), answer(ST_POOL_EMPT, 0, 0, 0));
        plan_chk(word_of(OP_FREE, 0, 0, 0, 0, 0, 0), answer(ST_DEV_EMPT, 0, 0, 0));
        plan_chk(word_of(OP_ALLOC, 7, 0, 0, 0, 0, 0), answer(ST_ILL_DEV, 0, 0, 0));
        plan_chk(word_of(OP_FREE, 7, 0, 0, 0, 0, 0), answer(ST_ILL_DEV, 0, 0, 0));
        plan_chk(word_of(OP_IDLE, 3, 1023, 1, 1, '1, '1), answer(ST_OK, 0, 0, 0));
        plan_chk(word_of(OP_SCAN, 0, 1023, 0, 0, 0, 0), answer(ST_OK, 1023, 0, 1));
        plan_chk(word_of(OP_SCAN, 0, 0, 0, 0, 0, 0), answer(ST_OK, 0, 0, 2));
        // Device checked before the header number.
        plan_chk(word_of(OP_SCAN, 6, 9, 1, 0, '1, 0), answer(ST_ILL_DEV, 0, 0, 2));
        plan_chk(word_of(OP_SCAN, 0, 9, 1, 0, '1, 0), answer(ST_ILL_NUM, 0, 0, 2));
        plan_chk(word_of(OP_SCAN, 0, 9, 1, 0, 1024, 0), answer(ST_ILL_NUM, 0, 0, 2));
        plan_chk(word_of(OP_SCAN, 0, 5, 1, 1, 3, 0), answer(ST_OK, 5, 3, 2));
        plan_chk(word_of(OP_SCAN, 0, 6, 1, 0, 3, 0), answer(ST_CLAIMED, 0, 0, 2));
        plan_chk(word_of(OP_SCAN, 0, 7, 1, 0, 1023, 0), answer(ST_OK, 7, 1023, 2));
        // Allocate into the gappy list, overwrite position 3, free it back.
        plan_op(word_of(OP_ALLOC, 0, 0, 0, 0, 0, 0));
        plan_op(word_of(OP_ALLOC, 0, 0, 0, 0, 0, '1));
        plan_op(word_of(OP_FREE, 0, 0, 0, 0, 0, 0));
        plan_cfg(CFG_DEVICE_COUNT, 8);
        plan_cfg(CFG_BLOCK_COUNT, 4);
        // Scanned block beyond block_count, then fill the pool up to block_count.
        plan_op(word_of(OP_SCAN, 2, 4, 0, 0, 0, 0));
        plan_op(word_of(OP_SCAN, 2, 3, 0, 0, 0, 0));
        plan_op(word_of(OP_SCAN, 2, 2, 0, 0, 0, 0));
        plan_op(word_of(OP_SCAN, 2, 1, 0, 0, 0, 0));
        plan_op(word_of(OP_ALLOC, 7, 0, 0, 0, 0, 32'h8000_0000));
        plan_cfg(CFG_BLOCK_COUNT, 0);
        // Zero blocks: device list counts as full, scans out of range, pool shut.
        plan_op(word_of(OP_ALLOC, 1, 0, 0, 0, 0, 0));
        plan_op(word_of(OP_SCAN, 1, 0, 0, 0, 0, 0));
        plan_op(word_of(OP_FREE, 0, 0, 0, 0, 0, 0));
        plan_op(word_of(OP_FREE, 0, 0, 0, 0, 0, 0));
        plan_op(word_of(OP_FREE, 0, 0, 0, 0, 0, 0));

        // Reset: hold it, then release on an edge.
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg)
                write_reg(plan[k].idx, plan[k].val);
            else
                issue_op(plan[k].word, plan[k].typed, plan[k].want);
        end

        // Random phases, one register setting each.
        foreach (set_devs[p]) begin
            write_reg(CFG_DEVICE_COUNT, {7'($urandom_range(0, 127)), 4'(set_devs[p])});
            write_reg(CFG_BLOCK_COUNT, 11'(set_blks[p]));
            for (int i = 0; i < set_items[p]; i++) begin
                // Every so often run a stretch with no idling at all.
                if (i % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if (p == 1 && i == 30)
                    hold_go = 1'b1;
                if (p == 5 && i == 80) begin
                    in_valid <= 1'b0;
                    while (due_results.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
                issue_op(draw_op(), 1'b0, '0);
            end
        end

        // Wind down: drop valid, wait for the last words, watch for strays.
        in_valid <= 1'b0;
        no_idle = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d words: %0d scan, %0d allocate, %0d free, %0d unused, %0d writes.",
                 results_seen, op_tally[OP_SCAN], op_tally[OP_ALLOC], op_tally[OP_FREE],
                 op_tally[OP_IDLE], settings_used);
        $display("Outcomes: ok %0d, claimed %0d, bad number %0d, pool empty %0d, %s %0d, %s %0d.",
                 status_tally[ST_OK], status_tally[ST_CLAIMED], status_tally[ST_ILL_NUM],
                 status_tally[ST_POOL_EMPT], "device empty", status_tally[ST_DEV_EMPT],
                 "bad device", status_tally[ST_ILL_DEV]);
        if (mismatches == 0) begin
            $display("** random_block_pool_allocator: PASSED **");
        end else begin
            $display("** random_block_pool_allocator: FAILED **");
        end
        $finish;
    end

endmodule
